/* rtl/npcs_pkg.sv */
`timescale 1ns / 1ps

package npcs_pkg;

  localparam int unsigned COMP_W = 8;
  localparam int unsigned DIST_W = 10;

  // Largest possible L1 distance between two 8-bit RGB colours.
  localparam logic [DIST_W-1:0] MAX_DISTANCE = 10'd765;

  typedef struct packed {
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
  } color_t;

  typedef enum logic {
    OP_WRITE    = 1'b0,
    OP_QUANTIZE = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_DONE
  } state_e;

endpackage

/* rtl/npcs_l1_unit.sv */
`timescale 1ns / 1ps

module npcs_l1_unit
  import npcs_pkg::*;
(
  input  logic              clk_i,
  input  color_t            entry_i,
  input  color_t            pixel_i,
  output logic [DIST_W-1:0] dist_o
);

  logic [COMP_W-1:0] diff_r;
  logic [COMP_W-1:0] diff_g;
  logic [COMP_W-1:0] diff_b;
  logic [DIST_W-1:0] dist_d;
  logic [DIST_W-1:0] dist_q;

  always_comb begin
    diff_r = (entry_i.red >= pixel_i.red) ? entry_i.red - pixel_i.red
                                          : pixel_i.red - entry_i.red;
    diff_g = (entry_i.green >= pixel_i.green) ? entry_i.green - pixel_i.green
                                              : pixel_i.green - entry_i.green;
    diff_b = (entry_i.blue >= pixel_i.blue) ? entry_i.blue - pixel_i.blue
                                            : pixel_i.blue - entry_i.blue;
    dist_d = DIST_W'(diff_r) + DIST_W'(diff_g) + DIST_W'(diff_b);
  end

  always_ff @(posedge clk_i) begin
    dist_q <= dist_d;
  end

  assign dist_o = dist_q;

endmodule

/* rtl/nearest_palette_color_search_core.sv */
`timescale 1ns / 1ps

// Nearest palette colour search by Manhattan distance.
//
// A transaction is accepted on a rising edge with start_i high and busy_o low.
// With opcode_i at OP_WRITE the colour is stored at entry_index_i in the
// palette memory in that same cycle; busy_o stays low and there is no result.
// With OP_QUANTIZE the block goes busy and walks entries 0 to palette_size-1
// (saturated to PALETTE_DEPTH), reading one entry per cycle from the single
// memory read port into a shared distance unit and a running minimum.
// The result appears on palette_index_o for exactly one cycle, marked by
// result_valid_o, once the last entry has passed the memory read register
// and the registered distance unit; busy_o falls in the cycle after that.
// An empty search reads no entry. The receiver cannot stall.
// palette_size is written through cfg_we_i / cfg_wdata_i; the user must
// write it only while idle, as the block itself does not enforce this.
// Reset clears the sequencer and sets palette_size to 0; palette contents are
// undefined until written.

module nearest_palette_color_search_core
  import npcs_pkg::*;
#(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic                opcode_i,
  input  logic [COMP_W-1:0]   entry_index_i,
  input  logic [COMP_W-1:0]   red_i,
  input  logic [COMP_W-1:0]   green_i,
  input  logic [COMP_W-1:0]   blue_i,
  input  logic                cfg_we_i,
  input  logic [8:0]          cfg_wdata_i,
  output logic                result_valid_o,
  output logic [COMP_W-1:0]   palette_index_o
);

  localparam int unsigned AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(PALETTE_DEPTH + 1);

  state_e state_q, state_d;

  logic [8:0]        palette_size_q;
  logic [CW-1:0]     limit_q, limit_d;
  logic [CW-1:0]     rd_cnt_q, rd_cnt_d;
  color_t            pix_q;
  logic [DIST_W-1:0] best_dist_q, best_dist_d;
  logic [AW-1:0]     best_idx_q, best_idx_d;

  // Read pipeline: memory data stage, then distance stage.
  logic              v1_q, v2_q;
  logic [AW-1:0]     idx1_q, idx2_q;
  logic              issue;
  color_t            rdata_q;
  logic [DIST_W-1:0] entry_dist;

  color_t            mem [PALETTE_DEPTH];

  logic              accept;
  logic              write_en;
  logic              search_done;

  assign accept   = start_i && !busy_o;
  assign write_en = accept && (opcode_i == OP_WRITE)
                    && ({1'b0, entry_index_i} < 9'(PALETTE_DEPTH));
  assign issue    = (state_q == S_SEARCH) && (rd_cnt_q < limit_q);
  assign search_done = (rd_cnt_q == limit_q) && !v1_q && !v2_q;

  always_ff @(posedge clk_i) begin
    if (write_en) begin
      mem[entry_index_i[AW-1:0]] <= color_t'({red_i, green_i, blue_i});
    end
    rdata_q <= mem[rd_cnt_q[AW-1:0]];
  end

  npcs_l1_unit u_l1 (
    .clk_i   (clk_i),
    .entry_i (rdata_q),
    .pixel_i (pix_q),
    .dist_o  (entry_dist)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && opcode_i == OP_QUANTIZE) begin
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (search_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    busy_o          = 1'b0;
    result_valid_o  = 1'b0;
    palette_index_o = COMP_W'(best_idx_q);
    unique case (state_q)
      S_IDLE:   busy_o = 1'b0;
      S_SEARCH: busy_o = 1'b1;
      S_DONE: begin
        busy_o         = 1'b1;
        result_valid_o = 1'b1;
      end
      default:  busy_o = 1'b1;
    endcase
  end

  // Datapath next values.
  always_comb begin
    limit_d     = limit_q;
    rd_cnt_d    = rd_cnt_q;
    best_dist_d = best_dist_q;
    best_idx_d  = best_idx_q;
    if (accept && opcode_i == OP_QUANTIZE) begin
      limit_d     = (palette_size_q > 9'(PALETTE_DEPTH)) ? CW'(PALETTE_DEPTH)
                                                         : CW'(palette_size_q);
      rd_cnt_d    = '0;
      best_dist_d = MAX_DISTANCE;
      best_idx_d  = '0;
    end else begin
      if (issue) begin
        rd_cnt_d = rd_cnt_q + CW'(1);
      end
      // Strictly smaller only, so the lowest index wins a tie.
      if (v2_q && entry_dist < best_dist_q) begin
        best_dist_d = entry_dist;
        best_idx_d  = idx2_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      palette_size_q <= '0;
      limit_q        <= '0;
      rd_cnt_q       <= '0;
      best_dist_q    <= MAX_DISTANCE;
      best_idx_q     <= '0;
      v1_q           <= 1'b0;
      v2_q           <= 1'b0;
    end else begin
      state_q     <= state_d;
      limit_q     <= limit_d;
      rd_cnt_q    <= rd_cnt_d;
      best_dist_q <= best_dist_d;
      best_idx_q  <= best_idx_d;
      v1_q        <= issue;
      v2_q        <= v1_q;
      if (cfg_we_i) begin
        palette_size_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx1_q <= rd_cnt_q[AW-1:0];
    idx2_q <= idx1_q;
    if (accept && opcode_i == OP_QUANTIZE) begin
      pix_q <= color_t'({red_i, green_i, blue_i});
    end
  end

  a_result_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_o)
    else $error("result strobe outside a busy period");

  a_result_then_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !busy_o && !result_valid_o)
    else $error("block did not return to idle after the result");

  a_quantize_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && opcode_i == OP_QUANTIZE) |=> busy_o && !result_valid_o)
    else $error("quantize transaction did not start a search");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH) |-> (rd_cnt_q <= limit_q))
    else $error("read counter ran past the search limit");

  a_best_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    best_dist_q <= MAX_DISTANCE)
    else $error("best distance above the largest possible distance");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import npcs_pkg::*;

  localparam int unsigned DEPTH = 256;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned SETTLE_CYCLES = 8;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic              busy_o;
  logic              opcode_i = OP_WRITE;
  logic [COMP_W-1:0] entry_index_i = '0;
  logic [COMP_W-1:0] red_i = '0;
  logic [COMP_W-1:0] green_i = '0;
  logic [COMP_W-1:0] blue_i = '0;
  logic              cfg_we_i = 1'b0;
  logic [8:0]        cfg_wdata_i = '0;
  logic              result_valid_o;
  logic [COMP_W-1:0] palette_index_o;

  // Predictor state: a shadow palette and the current search size.
  color_t            palette_shadow [DEPTH];
  logic [8:0]        searched_entries = '0;
  logic [COMP_W-1:0] nearest_index_q [$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned sender_idle_pct = 0;
  logic        busy_sampled = 1'b1;

  nearest_palette_color_search_core #(
    .PALETTE_DEPTH(DEPTH)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .opcode_i       (opcode_i),
    .entry_index_i  (entry_index_i),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .palette_index_o(palette_index_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int unsigned abs_diff(input logic [COMP_W-1:0] a,
                                           input logic [COMP_W-1:0] b);
    return (a >= b) ? int'(a - b) : int'(b - a);
  endfunction

  function automatic logic [COMP_W-1:0] nearest_entry(input color_t pixel);
    int unsigned       limit;
    int unsigned       l1_dist;
    int unsigned       best_dist;
    logic [COMP_W-1:0] best_entry;
    limit = (int'(searched_entries) > DEPTH) ? DEPTH : int'(searched_entries);
    best_dist = int'(MAX_DISTANCE);
    best_entry = '0;
    for (int unsigned i = 0; i < limit; i++) begin
      l1_dist = abs_diff(palette_shadow[COMP_W'(i)].red, pixel.red)
              + abs_diff(palette_shadow[COMP_W'(i)].green, pixel.green)
              + abs_diff(palette_shadow[COMP_W'(i)].blue, pixel.blue);
      // Strictly smaller only, so the lowest index keeps a tie.
      if (l1_dist < best_dist) begin
        best_dist = l1_dist;
        best_entry = COMP_W'(i);
      end
    end
    return best_entry;
  endfunction

  function automatic color_t random_colour();
    logic [23:0] bits;
    bits = 24'($urandom);
    return color_t'(bits);
  endfunction

  function automatic logic [COMP_W-1:0] jitter(input logic [COMP_W-1:0] c);
    int v;
    v = int'(c) + $urandom_range(16) - 8;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return COMP_W'(v);
  endfunction

  // Outputs are sampled mid-cycle, where they are settled for the next edge.
  always @(negedge clk_i) busy_sampled = busy_o;

  always @(negedge clk_i) begin : check_results
    logic [COMP_W-1:0] expected;
    if (rst_ni && result_valid_o === 1'b1) begin
      if (nearest_index_q.size() == 0) begin
        $error("palette_index: expected none, actual %0d", palette_index_o);
        error_count++;
      end else begin
        expected = nearest_index_q.pop_front();
        if (palette_index_o !== expected) begin
          $error("palette_index: expected %0d, actual %0d", expected, palette_index_o);
          error_count++;
        end
      end
    end
  end

  task automatic send_item(input opcode_e op, input logic [COMP_W-1:0] index,
                           input color_t colour);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i       <= 1'b1;
    opcode_i      <= op;
    entry_index_i <= index;
    red_i         <= colour.red;
    green_i       <= colour.green;
    blue_i        <= colour.blue;
    do @(posedge clk_i); while (busy_sampled !== 1'b0);
    if (op == OP_WRITE) begin
      palette_shadow[index] = colour;
    end else begin
      nearest_index_q.push_back(nearest_entry(colour));
    end
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    while (nearest_index_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_palette_size(input logic [8:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    searched_entries = value;
  endtask

  task automatic test_empty_palette();
    send_item(OP_QUANTIZE, 8'hFF, random_colour());
    set_palette_size(9'd0);
    send_item(OP_QUANTIZE, 8'h00, color_t'(24'hFFFFFF));
  endtask

  task automatic test_ties_and_extremes();
    send_item(OP_WRITE, 8'd0, color_t'(24'h000000));
    send_item(OP_WRITE, 8'd1, color_t'(24'hFFFFFF));
    send_item(OP_WRITE, 8'd2, color_t'(24'hFFFFFF));
    send_item(OP_WRITE, 8'd3, color_t'(24'h8040C0));
    set_palette_size(9'd4);
    send_item(OP_QUANTIZE, 8'd0, color_t'(24'hFFFFFF));
    send_item(OP_QUANTIZE, 8'hFF, color_t'(24'h000000));
    send_item(OP_QUANTIZE, 8'd3, color_t'(24'h8040C0));
    send_item(OP_QUANTIZE, 8'd7, color_t'(24'h7F41C0));
    send_item(OP_QUANTIZE, 8'hAA, color_t'(24'hFF00FF));
  endtask

  task automatic test_nothing_below_max();
    // Only black is searched, so a white pixel is 765 away from everything.
    set_palette_size(9'd1);
    send_item(OP_QUANTIZE, 8'h55, color_t'(24'hFFFFFF));
    send_item(OP_QUANTIZE, 8'h55, color_t'(24'h000000));
  endtask

  task automatic test_fill_palette();
    color_t colour;
    for (int unsigned i = 0; i < DEPTH; i++) begin
      case ($urandom_range(7))
        0: colour = color_t'(24'h000000);
        1: colour = color_t'(24'hFFFFFF);
        default: colour = random_colour();
      endcase
      send_item(OP_WRITE, COMP_W'(i), colour);
    end
  endtask

  task automatic test_size_saturation();
    logic [8:0] sizes [3];
    sizes = '{9'd256, 9'd257, 9'd511};
    foreach (sizes[k]) begin
      set_palette_size(sizes[k]);
      send_item(OP_QUANTIZE, 8'h00, palette_shadow[COMP_W'(DEPTH-1)]);
      send_item(OP_QUANTIZE, 8'h80, random_colour());
    end
  endtask

  task automatic test_random_traffic(input int unsigned item_count,
                                     input int unsigned idle_pct);
    int unsigned sent;
    int unsigned run_length;
    int unsigned roll;
    int unsigned limit;
    color_t      colour;
    logic [8:0]  new_size;
    sender_idle_pct = idle_pct;
    sent = 0;
    while (sent < item_count) begin
      // Mostly short searches; the full depth and its saturated range are rare.
      roll = $urandom_range(99);
      if (roll < 4)       new_size = 9'd0;
      else if (roll < 70) new_size = 9'($urandom_range(16, 1));
      else if (roll < 92) new_size = 9'($urandom_range(64, 17));
      else if (roll < 96) new_size = 9'($urandom_range(255, 65));
      else                new_size = 9'($urandom_range(511, 256));
      set_palette_size(new_size);
      limit = (int'(new_size) > DEPTH) ? DEPTH : int'(new_size);
      run_length = $urandom_range(32, 8);
      for (int unsigned n = 0; n < run_length && sent < item_count; n++) begin
        if ($urandom_range(99) < 30) begin
          // A copied colour sets up ties between entries.
          if ($urandom_range(3) == 0)
            colour = palette_shadow[COMP_W'($urandom_range(DEPTH - 1))];
          else
            colour = random_colour();
          send_item(OP_WRITE, COMP_W'($urandom_range(DEPTH - 1)), colour);
        end else begin
          if (limit != 0 && $urandom_range(1) == 0) begin
            colour = palette_shadow[COMP_W'($urandom_range(limit - 1))];
            colour.red   = jitter(colour.red);
            colour.green = jitter(colour.green);
            colour.blue  = jitter(colour.blue);
          end else begin
            colour = random_colour();
          end
          send_item(OP_QUANTIZE, COMP_W'($urandom), colour);
        end
        sent++;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_palette();
    test_ties_and_extremes();
    test_nothing_below_max();
    test_fill_palette();
    test_size_saturation();
    test_random_traffic(480, 29);
    test_random_traffic(480, 67);
    test_random_traffic(480, 0);
    wait_drained();
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/npcs_pkg.sv
rtl/npcs_l1_unit.sv
rtl/nearest_palette_color_search_core.sv
tb/tb_top.sv
